@@ hdl/instruction_class_counter_bank_unit_assert.svh @@
// Assertion macros for the instruction class counter bank.
// Used by the top level; relies on a clock and an active-low reset passed in.
`ifndef INSTRUCTION_CLASS_COUNTER_BANK_UNIT_ASSERT_SVH
`define INSTRUCTION_CLASS_COUNTER_BANK_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ICC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("icc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ICC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("icc assertion failed");

`endif

@@ hdl/icc_pkg.sv @@
// Shared constants for the instruction class counter bank.
// No dependencies; imported by the top level.
package icc_pkg;

  localparam int NUM_CLASSES  = 43;
  localparam int WINDOW_BYTES = 4096;

  localparam int IDX_W  = $clog2(NUM_CLASSES);
  localparam int WORD_W = $clog2(WINDOW_BYTES) - 2;

  localparam logic [31:0] CTRL_VALUE = 32'h1;

  localparam logic [1:0] REQ_INC   = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;

  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_UNMAPPED     = 2'd1;
  localparam logic [1:0] ST_CTRL_IGNORED = 2'd2;

endpackage

@@ hdl/instruction_class_counter_bank_unit.sv @@
// Instruction class counter bank: 43 wrapping 32-bit counters behind a register window.
// Depends on icc_pkg, icc_ram and instruction_class_counter_bank_unit_assert.svh.
//
// Usage:
// An item is transferred when start is high and busy is low. It is either an
// increment event, a bus read or a bus write. Increments produce no result.
// Each bus read or write produces one result on out_read_data and
// out_access_status, marked by out_valid for exactly one cycle once the transfer has
// passed the p1 and output registers. The receiver cannot stall; results are always
// taken. Throughput is one item per cycle while busy is low. The counters live in a
// RAM that is read in the transfer cycle and written back in the next cycle; a
// write-back register forwards the latest value to a back-to-back access of the same
// counter. A valid bit for each counter makes never-written counters read as zero, so
// reset clears the bank at once without a clearing pass.
// busy is high for the first cycle after reset and low from then on.
// window_base is written through cfg_valid/cfg_ready while the block is idle
// and resets to zero.
module instruction_class_counter_bank_unit
  import icc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic [5:0]  in_inst_class,
  input  logic [31:0] in_bus_address,
  input  logic [31:0] in_write_data,
  output logic        out_valid,
  output logic [31:0] out_read_data,
  output logic [1:0]  out_access_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_window_base
);

  `include "instruction_class_counter_bank_unit_assert.svh"

  typedef enum logic [2:0] {
    OP_INC,
    OP_READ_CNT,
    OP_READ_CTRL,
    OP_WRITE_CNT,
    OP_WRITE_CTRL,
    OP_UNMAPPED
  } op_t;

  logic                   busy_r;
  logic [31:0]            window_base_r;

  logic                   accept;
  logic [31:0]            offset;
  logic [WORD_W-1:0]      word;
  logic                   mapped;
  logic                   cls_ok;
  logic                   issue;
  op_t                    op_nxt;
  logic [IDX_W-1:0]       idx_nxt;

  logic                   p1_vld_r;
  op_t                    p1_op_r;
  logic [IDX_W-1:0]       p1_idx_r;
  logic [31:0]            p1_wdata_r;
  logic                   p1_ent_vld_r;

  logic [NUM_CLASSES-1:0] ent_vld_r;
  logic                   wb_vld_r;
  logic [IDX_W-1:0]       wb_idx_r;
  logic [31:0]            wb_data_r;

  logic [31:0]            ram_rdata;
  logic [31:0]            cur;
  logic                   we;
  logic [31:0]            new_val;

  logic                   out_valid_r;
  logic [31:0]            out_read_data_r;
  logic [1:0]             out_access_status_r;
  logic                   out_valid_nxt;
  logic [31:0]            out_read_data_nxt;
  logic [1:0]             out_access_status_nxt;

  assign busy      = busy_r;
  assign cfg_ready = ~busy_r;
  assign accept    = start && !busy_r;

  assign offset = in_bus_address - window_base_r;
  assign word   = offset[2 +: WORD_W];
  assign mapped = (offset < 32'(WINDOW_BYTES)) && (32'(word) <= 32'(NUM_CLASSES));
  assign cls_ok = (in_inst_class != 6'd0) && (32'(in_inst_class) <= 32'(NUM_CLASSES));

  always_comb begin
    issue   = 1'b0;
    op_nxt  = OP_UNMAPPED;
    idx_nxt = '0;
    unique case (in_req_type) inside
      REQ_INC: begin
        issue   = cls_ok;
        op_nxt  = OP_INC;
        idx_nxt = IDX_W'(32'(in_inst_class) - 32'd1);
      end
      REQ_READ, REQ_WRITE: begin
        issue = 1'b1;
        if (!mapped) begin
          op_nxt = OP_UNMAPPED;
        end else if (word == '0) begin
          op_nxt = (in_req_type == REQ_READ) ? OP_READ_CTRL : OP_WRITE_CTRL;
        end else begin
          op_nxt  = (in_req_type == REQ_READ) ? OP_READ_CNT : OP_WRITE_CNT;
          idx_nxt = IDX_W'(32'(word) - 32'd1);
        end
      end
      default: begin
        issue = 1'b0;
      end
    endcase
  end

  icc_ram #(
    .WIDTH(32),
    .DEPTH(NUM_CLASSES)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(p1_idx_r),
    .wdata(new_val),
    .raddr(idx_nxt),
    .rdata(ram_rdata)
  );

  always_comb begin
    if (wb_vld_r && (wb_idx_r == p1_idx_r)) begin
      cur = wb_data_r;
    end else if (p1_ent_vld_r) begin
      cur = ram_rdata;
    end else begin
      cur = '0;
    end
    we      = p1_vld_r && ((p1_op_r == OP_INC) || (p1_op_r == OP_WRITE_CNT));
    new_val = (p1_op_r == OP_INC) ? cur + 32'd1 : p1_wdata_r;

    out_valid_nxt         = p1_vld_r && (p1_op_r != OP_INC);
    out_read_data_nxt     = '0;
    out_access_status_nxt = ST_OK;
    case (p1_op_r)
      OP_READ_CNT:   out_read_data_nxt     = cur;
      OP_READ_CTRL:  out_read_data_nxt     = CTRL_VALUE;
      OP_WRITE_CTRL: out_access_status_nxt = ST_CTRL_IGNORED;
      OP_UNMAPPED:   out_access_status_nxt = ST_UNMAPPED;
      default:       out_read_data_nxt     = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r        <= 1'b1;
      window_base_r <= '0;
      p1_vld_r      <= 1'b0;
      ent_vld_r     <= '0;
      wb_vld_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      busy_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        window_base_r <= cfg_window_base;
      end
      p1_vld_r <= accept && issue;
      wb_vld_r <= we;
      if (we) begin
        ent_vld_r[p1_idx_r] <= 1'b1;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p1_op_r      <= op_nxt;
    p1_idx_r     <= idx_nxt;
    p1_wdata_r   <= in_write_data;
    p1_ent_vld_r <= (32'(idx_nxt) < 32'(NUM_CLASSES)) ? ent_vld_r[idx_nxt] : 1'b0;
    wb_idx_r     <= p1_idx_r;
    wb_data_r    <= new_val;
    out_read_data_r     <= out_read_data_nxt;
    out_access_status_r <= out_access_status_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_read_data     = out_read_data_r;
  assign out_access_status = out_access_status_r;

  `ICC_ASSERT_NEXT(a_bus_reaches_p1, clk, rst_n,
    accept && ((in_req_type == REQ_READ) || (in_req_type == REQ_WRITE)),
    p1_vld_r && (p1_op_r != OP_INC))
  `ICC_ASSERT_NEXT(a_p1_gives_result, clk, rst_n,
    p1_vld_r && (p1_op_r != OP_INC), out_valid_r)
  `ICC_ASSERT_SAME(a_no_data_on_error, clk, rst_n,
    out_valid_r && (out_access_status_r != ST_OK), out_read_data_r == 32'd0)

endmodule

@@ hdl/icc_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module icc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
